FILE: hdl/mrt_pkg.sv
// Package: widths, request codes, packed entry type and state codes for the region table.
`timescale 1ns / 1ps
`default_nettype none
package mrt_pkg;
  localparam int ENTRIES    = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int PAGE_W     = $clog2(PAGE_BYTES);

  localparam int SPACE_W = 52;
  localparam int ADDR_W  = 48;
  localparam int IMG_W   = 64;
  localparam int FLAG_W  = 32;

  localparam int IN_DATA_W  = 360;
  localparam int OUT_DATA_W = 160;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_FIND    = 2'd1;
  localparam logic [1:0] KIND_INHERIT = 2'd2;
  localparam logic [1:0] KIND_FORGET  = 2'd3;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  typedef struct packed {
    logic [SPACE_W-1:0] space;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  length;
    logic [IMG_W-1:0]   image;
    logic [IMG_W-1:0]   offset;
    logic [FLAG_W-1:0]  flags;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

FILE: hdl/mrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  wire logic [WIDTH-1:0]                              wr_data,
  input  wire logic                                          rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output      logic [WIDTH-1:0]                              rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

FILE: hdl/mapped_region_table_top.sv
// Top level of the mapped region table: request sequencer around one entry RAM.
// Add writes the entry straight from idle and then goes to done.
// Find and forget read, then check, one entry at a time (read and check states).
// Inherit scans twice (count, then copy). A stalled result holds the sequencer in done.
// Synchronous active-low reset clears the used marks and control state; entry RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module mapped_region_table_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  // address_space[51:0], address[99:52], length[147:100], image_handle[211:148],
  // image_offset[275:212], region_flags[307:276], target_space[359:308]
  input  wire logic [mrt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]                     in_tuser,  // kind
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // found_image[63:0], found_offset[127:64], found_flags[159:128]
  output      logic [mrt_pkg::OUT_DATA_W-1:0] out_tdata,
  output      logic                           out_tuser  // ok
);
  import mrt_pkg::*;

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic                 phase_r, phase_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     want_r, want_nxt;
  logic                 ok_r, ok_nxt;
  logic [ENTRIES-1:0]   used_r, used_nxt;
  logic [SPACE_W-1:0]   space_r, target_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [IMG_W-1:0]     hit_img_r, hit_off_r;
  logic [FLAG_W-1:0]    hit_flg_r;
  logic [ADDR_W-1:0]    hit_dist_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 out_ok_r;

  logic                 in_xfer;
  logic [SPACE_W-1:0]   in_space, in_target;
  logic [ADDR_W-1:0]    in_addr, in_len;
  logic [IMG_W-1:0]     in_img, in_off;
  logic [FLAG_W-1:0]    in_flg;

  logic                 free_any;
  logic [IDX_W-1:0]     free_idx;
  logic [CNT_W-1:0]     free_cnt;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  entry_t               wdata;
  logic                 re;
  entry_t               rdata;

  logic                 match, in_range, last;
  logic [ADDR_W:0]      end_addr;
  logic [ADDR_W-1:0]    pg_dist;
  logic                 hit_cap;
  logic [IDX_W-1:0]     cur;

  assign in_space  = in_tdata[51:0];
  assign in_addr   = in_tdata[99:52];
  assign in_len    = in_tdata[147:100];
  assign in_img    = in_tdata[211:148];
  assign in_off    = in_tdata[275:212];
  assign in_flg    = in_tdata[307:276];
  assign in_target = in_tdata[359:308];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cur       = idx_r[IDX_W-1:0];

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    free_cnt = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (!used_r[k]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(k);
        free_cnt = free_cnt + CNT_W'(1);
      end
    end
  end

  assign match    = used_r[cur] && (rdata.space == space_r);
  assign end_addr = {1'b0, rdata.base} + {1'b0, rdata.length};
  assign in_range = (addr_r >= rdata.base) && ({1'b0, addr_r} < end_addr);
  assign pg_dist  = (addr_r - rdata.base) & ~ADDR_W'(PAGE_BYTES - 1);
  assign last     = (idx_r == CNT_W'(ENTRIES - 1));

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    want_nxt  = want_r;
    ok_nxt    = ok_r;
    used_nxt  = used_r;
    we        = 1'b0;
    waddr     = free_idx;
    wdata     = rdata;
    re        = 1'b0;
    hit_cap   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          kind_nxt  = in_tuser;
          phase_nxt = 1'b0;
          idx_nxt   = '0;
          want_nxt  = '0;
          ok_nxt    = 1'b0;
          if (in_tuser == KIND_ADD) begin
            state_nxt = ST_DONE;
            if (in_space != '0 && in_len != '0 && in_img != '0 && free_any) begin
              we              = 1'b1;
              wdata           = '{in_space, in_addr, in_len, in_img, in_off, in_flg};
              used_nxt[free_idx] = 1'b1;
              ok_nxt          = 1'b1;
            end
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        re        = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = ST_RD;
        idx_nxt   = idx_r + CNT_W'(1);
        if (last) begin
          state_nxt = ST_DONE;
        end
        unique case (kind_r)
          KIND_FIND: begin
            if (match && in_range) begin
              hit_cap   = 1'b1;
              ok_nxt    = 1'b1;
              state_nxt = ST_DONE;
            end
          end
          KIND_FORGET: begin
            if (match) begin
              used_nxt[cur] = 1'b0;
            end
            ok_nxt = 1'b1;
          end
          KIND_INHERIT: begin
            if (!phase_r) begin
              if (match) begin
                want_nxt = want_r + CNT_W'(1);
              end
              if (last) begin
                if (want_nxt <= free_cnt) begin
                  ok_nxt = 1'b1;
                  if (want_nxt != '0) begin
                    phase_nxt = 1'b1;
                    idx_nxt   = '0;
                    state_nxt = ST_RD;
                  end
                end
              end
            end else if (match) begin
              we                 = 1'b1;
              wdata.space        = target_r;
              used_nxt[free_idx] = 1'b1;
              want_nxt           = want_r - CNT_W'(1);
              if (want_nxt == '0) begin
                state_nxt = ST_DONE;
              end
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  mrt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_entries (
    .clk    (clk),
    .wr_en  (we),
    .wr_addr(waddr),
    .wr_data(wdata),
    .rd_en  (re),
    .rd_addr(cur),
    .rd_data(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_ADD;
      phase_r     <= 1'b0;
      idx_r       <= '0;
      want_r      <= '0;
      ok_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      kind_r  <= kind_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      want_r  <= want_nxt;
      ok_r    <= ok_nxt;
      if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      space_r  <= in_space;
      target_r <= in_target;
      addr_r   <= in_addr;
    end
    if (hit_cap) begin
      hit_img_r  <= rdata.image;
      hit_off_r  <= rdata.offset;
      hit_flg_r  <= rdata.flags;
      hit_dist_r <= pg_dist;
    end
    if (state_r == ST_DONE && (!out_valid_r || out_tready)) begin
      out_ok_r <= ok_r;
      if (ok_r && kind_r == KIND_FIND) begin
        out_data_r <= {hit_flg_r, hit_off_r + {{(IMG_W - ADDR_W){1'b0}}, hit_dist_r}, hit_img_r};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

`ifndef SYNTHESIS
  a_add_takes_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_xfer && in_tuser == KIND_ADD && we)
      |=> $countones(used_r) == $past($countones(used_r)) + 1)
    else $error("add did not claim exactly one slot");
  a_copy_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK && kind_r == KIND_INHERIT && phase_r && match) |-> free_any)
    else $error("inherit copy with no free slot");
  a_forget_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK && kind_r == KIND_FORGET)
      |=> $countones(used_r) <= $past($countones(used_r)))
    else $error("forget set a used mark");
  a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (state_r == ST_DONE || state_r == ST_IDLE))
    else $error("bad exit from done");
`endif
endmodule
`default_nettype wire

FILE: bench/mapped_region_table_top_test.sv
// Testbench for the mapped region table: directed and random requests against a local table model.
`timescale 1ns / 1ps
module mapped_region_table_top_test;
  import mrt_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic [SPACE_W-1:0] space;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  len;
    logic [IMG_W-1:0]   img;
    logic [IMG_W-1:0]   offs;
    logic [FLAG_W-1:0]  flags;
    logic [SPACE_W-1:0] target;
  } region_req_t;

  typedef struct {
    logic             ok;
    logic [IMG_W-1:0] img;
    logic [IMG_W-1:0] offs;
    logic [FLAG_W-1:0] flags;
  } region_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = KIND_ADD;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  mapped_region_table_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the table
  logic               slot_used [ENTRIES];
  logic [SPACE_W-1:0] slot_space[ENTRIES];
  logic [ADDR_W-1:0]  slot_base [ENTRIES];
  logic [ADDR_W-1:0]  slot_len  [ENTRIES];
  logic [IMG_W-1:0]   slot_img  [ENTRIES];
  logic [IMG_W-1:0]   slot_offs [ENTRIES];
  logic [FLAG_W-1:0]  slot_flags[ENTRIES];

  region_result_t pending_results[$];
  logic [SPACE_W-1:0] space_pool[6];
  bit idle_on = 1'b1;
  int stall_left = 0;
  int idle_cycles = 0;
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_ok = 0, n_hits = 0;
  int kind_count[4] = '{0, 0, 0, 0};

  function automatic region_result_t apply_request(region_req_t r);
    region_result_t res;
    logic [63:0] page_dist;
    int wanted, open_cnt;
    res = '{1'b0, '0, '0, '0};
    case (r.kind)
      KIND_ADD: begin
        if (r.space != 0 && r.len != 0 && r.img != 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_space[i] = r.space;
              slot_base[i] = r.addr;
              slot_len[i] = r.len;
              slot_img[i] = r.img;
              slot_offs[i] = r.offs;
              slot_flags[i] = r.flags;
              res.ok = 1'b1;
              break;
            end
          end
        end
      end
      KIND_FIND: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && slot_space[i] == r.space && r.addr >= slot_base[i] &&
              {1'b0, r.addr} < {1'b0, slot_base[i]} + {1'b0, slot_len[i]}) begin
            page_dist = 64'(r.addr - slot_base[i]);
            page_dist = (page_dist / PAGE_BYTES) * PAGE_BYTES;
            res = '{1'b1, slot_img[i], slot_offs[i] + page_dist, slot_flags[i]};
            break;
          end
        end
      end
      KIND_INHERIT: begin
        wanted = 0;
        open_cnt = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && slot_space[i] == r.space) wanted++;
          else if (!slot_used[i]) open_cnt++;
        end
        if (wanted <= open_cnt) begin
          res.ok = 1'b1;
          for (int i = 0; i < ENTRIES && wanted > 0; i++) begin
            if (slot_used[i] && slot_space[i] == r.space) begin
              wanted--;
              for (int j = 0; j < ENTRIES; j++) begin
                if (!slot_used[j]) begin
                  slot_used[j] = 1'b1;
                  slot_space[j] = r.target;
                  slot_base[j] = slot_base[i];
                  slot_len[j] = slot_len[i];
                  slot_img[j] = slot_img[i];
                  slot_offs[j] = slot_offs[i];
                  slot_flags[j] = slot_flags[i];
                  break;
                end
              end
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && slot_space[i] == r.space) slot_used[i] = 1'b0;
        res.ok = 1'b1;
      end
    endcase
    return res;
  endfunction

  task automatic send_request(region_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.kind;
    in_tdata <= {r.target, r.flags, r.offs, r.img, r.len, r.addr, r.space};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(apply_request(r));
    kind_count[r.kind]++;
    n_sent++;
  endtask

  function automatic region_req_t make_req(logic [1:0] kind, logic [SPACE_W-1:0] space,
                                           logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] len,
                                           logic [IMG_W-1:0] img, logic [IMG_W-1:0] offs,
                                           logic [FLAG_W-1:0] flags,
                                           logic [SPACE_W-1:0] target);
    region_req_t r;
    r = '{kind, space, addr, len, img, offs, flags, target};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic region_req_t random_request();
    region_req_t r;
    int pick, used_idx[$];
    r = make_req(2'($urandom), 52'(rand64()), 48'(rand64()), 48'(rand64()), rand64(),
                 rand64(), $urandom, 52'(rand64()));
    if ($urandom_range(0, 9) == 0) return r;  // noise: every field random
    r.space = space_pool[$urandom_range(0, 5)];
    r.target = space_pool[$urandom_range(0, 5)];
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.kind = KIND_ADD;
      if ($urandom_range(0, 3) != 0) r.len = 48'($urandom_range(1, 1 << 20));
    end else if (pick < 75) begin
      r.kind = KIND_FIND;
      for (int i = 0; i < ENTRIES; i++) if (slot_used[i]) used_idx.push_back(i);
      if (used_idx.size() > 0 && $urandom_range(0, 4) != 0) begin
        pick = used_idx[$urandom_range(0, used_idx.size() - 1)];
        r.space = slot_space[pick];
        r.addr = slot_base[pick] + 48'(rand64() % {16'd0, slot_len[pick]});
      end
    end else if (pick < 87) begin
      r.kind = KIND_INHERIT;
    end else begin
      r.kind = KIND_FORGET;
    end
    return r;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result check; a transfer seen here completes at the next rising edge
  always @(negedge clk) begin
    region_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (exp_res.ok) n_ok++;
        if (out_tuser !== exp_res.ok) begin
          $error("ok: expected %0h actual %0h", exp_res.ok, out_tuser);
          errors++;
        end
        if (out_tdata[63:0] !== exp_res.img) begin
          $error("found_image: expected %0h actual %0h", exp_res.img, out_tdata[63:0]);
          errors++;
        end
        if (out_tdata[127:64] !== exp_res.offs) begin
          $error("found_offset: expected %0h actual %0h", exp_res.offs, out_tdata[127:64]);
          errors++;
        end
        if (out_tdata[159:128] !== exp_res.flags) begin
          $error("found_flags: expected %0h actual %0h", exp_res.flags, out_tdata[159:128]);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 2000) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  localparam logic [SPACE_W-1:0] SPACE_MAX = '1;

  task automatic test_add_refusals();
    send_request(make_req(KIND_ADD, '0, 48'h1000, 48'h1000, 64'h1, 64'h0, 32'h1, '0));
    send_request(make_req(KIND_ADD, 52'h1, 48'h1000, '0, 64'h1, 64'h0, 32'h1, '0));
    send_request(make_req(KIND_ADD, 52'h1, 48'h1000, 48'h1000, '0, 64'h0, 32'h1, '0));
  endtask

  task automatic test_extremes();
    send_request(make_req(KIND_ADD, SPACE_MAX, '1, '1, '1, '1, '1, '0));
    send_request(make_req(KIND_FIND, SPACE_MAX, '1, '0, '0, '0, '0, '0));
    send_request(make_req(KIND_FIND, 52'h1, '1, '0, '0, '0, '0, '0));
    send_request(make_req(KIND_INHERIT, SPACE_MAX, '0, '0, '0, '0, '0, '0));
    send_request(make_req(KIND_FIND, '0, '1, '0, '0, '0, '0, '0));
  endtask

  task automatic test_full_table();
    for (int i = 0; i < ENTRIES - 2; i++)
      send_request(make_req(KIND_ADD, 52'h1, 48'(i * 48'h10000), 48'h8000, rand64() | 64'h1,
                            rand64(), $urandom, '0));
    send_request(make_req(KIND_ADD, 52'h2, 48'h0, 48'h10, 64'h5, 64'h0, 32'h0, '0));
    send_request(make_req(KIND_INHERIT, 52'h1, '0, '0, '0, '0, '0, 52'h2));
    send_request(make_req(KIND_FIND, 52'h1, 48'h37fff, '0, '0, '0, '0, '0));
  endtask

  task automatic test_forget_and_self_inherit();
    send_request(make_req(KIND_FORGET, 52'h9, '0, '0, '0, '0, '0, '0));
    send_request(make_req(KIND_FORGET, 52'h1, '0, '0, '0, '0, '0, '0));
    send_request(make_req(KIND_INHERIT, SPACE_MAX, '0, '0, '0, '0, '0, SPACE_MAX));
    send_request(make_req(KIND_FORGET, '0, '0, '0, '0, '0, '0, '0));
    send_request(make_req(KIND_FORGET, SPACE_MAX, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count - count / 10) idle_on = 1'b0;
      send_request(random_request());
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    space_pool = '{52'h1, 52'h2, 52'h3, 52'h8_0000_0000_0001, SPACE_MAX, 52'h0};
    for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_add_refusals();
    test_extremes();
    test_full_table();
    test_forget_and_self_inherit();
    test_random(1620);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * ENTRIES + 10) @(posedge clk);
    $display("%0d requests (add %0d, find %0d, inherit %0d, forget %0d), %0d results checked,",
             n_sent, kind_count[KIND_ADD], kind_count[KIND_FIND], kind_count[KIND_INHERIT],
             kind_count[KIND_FORGET], n_checked);
    $display("%0d of them successful; %0d mismatches", n_ok, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/mrt_pkg.sv
hdl/mrt_ram.sv
hdl/mapped_region_table_top.sv
bench/mapped_region_table_top_test.sv
